### rtl/imu_sample_scale_calibrate_defines.svh
`ifndef IMU_SAMPLE_SCALE_CALIBRATE_DEFINES_SVH
`define IMU_SAMPLE_SCALE_CALIBRATE_DEFINES_SVH

// cons must hold in the clock after ante
`define IMU_SSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imu_ssc: next-cycle check failed");

// cons must hold in the same clock as ante
`define IMU_SSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imu_ssc: same-cycle check failed");

`endif

### rtl/imu_ssc_pkg.sv
`default_nettype none
package imu_ssc_pkg;

   localparam int RAW_W       = 16;
   localparam int FACTOR_W    = 25;
   localparam int PROD_W      = 42;
   localparam int SCALE_SHIFT = 16;
   localparam int SCALED_W    = 25;
   localparam int BIAS_W      = 21;
   localparam int NB_W        = 26;
   localparam int COEF_W      = 16;
   localparam int DOT_W       = 44;
   localparam int ALIGN_SHIFT = 14;
   localparam int OUT_W       = 32;
   localparam int AXES        = 3;

   localparam int ACCEL_CODE_W = 2;
   localparam int GYRO_CODE_W  = 3;
   localparam int BIAS_PACK_W  = AXES * BIAS_W;
   localparam int ROW_W        = AXES * COEF_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int REQ_TDATA_W = AXES * RAW_W;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 2 * AXES * OUT_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PROD_W-1:0] SCALE_ROUND = PROD_W'(1) << (SCALE_SHIFT - 1);
   localparam logic [DOT_W-1:0]  ALIGN_ROUND = DOT_W'(1) << (ALIGN_SHIFT - 1);

   localparam logic [ACCEL_CODE_W-1:0] ACCEL_RANGE_RST = 2'd1;
   localparam logic [GYRO_CODE_W-1:0]  GYRO_RANGE_RST  = 3'd0;
   localparam logic [ROW_W-1:0] ALIGN_ROW_X_RST = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ALIGN_ROW_Y_RST = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ALIGN_ROW_Z_RST = 48'h4000_0000_0000;

   typedef logic signed [RAW_W-1:0]    raw_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SCALED_W-1:0] scaled_type;
   typedef logic signed [BIAS_W-1:0]   bias_type;
   typedef logic signed [NB_W-1:0]     nb_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [DOT_W-1:0]    dot_type;
   typedef logic signed [OUT_W-1:0]    out_type;
   typedef logic [FACTOR_W-1:0]        factor_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_RANGE = 3'd0,
      CSR_GYRO_RANGE  = 3'd1,
      CSR_ACCEL_BIAS  = 3'd2,
      CSR_GYRO_BIAS   = 3'd3,
      CSR_ALIGN_X     = 3'd4,
      CSR_ALIGN_Y     = 3'd5,
      CSR_ALIGN_Z     = 3'd6
   } csr_index_type;

   // classified word between front and back
   typedef struct packed {
      logic       err;
      logic       gyro;
      scaled_type sx;
      scaled_type sy;
      scaled_type sz;
   } item_type;

   // round(full_scale * 9.80665 * 2^32 / 32767)
   function automatic factor_type accel_scale(input logic [ACCEL_CODE_W-1:0] code);
      factor_type f;
      case (code)
         2'd0:    f = 25'd3856249;
         2'd1:    f = 25'd7712499;
         2'd2:    f = 25'd15424997;
         2'd3:    f = 25'd30849995;
         default: f = 25'd7712499;
      endcase
      return f;
   endfunction

   // round(full_scale * pi/180 * 2^32 / 32767); unused codes act as 125 deg/s
   function automatic factor_type gyro_scale(input logic [GYRO_CODE_W-1:0] code);
      factor_type f;
      case (code)
         3'd0:    f = 25'd4575416;
         3'd1:    f = 25'd2287708;
         3'd2:    f = 25'd1143854;
         3'd3:    f = 25'd571927;
         default: f = 25'd285963;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

### rtl/imu_ssc_front.sv
`default_nettype none
module imu_ssc_front import imu_ssc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TUSER_W-1:0]  req_tuser,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [ACCEL_CODE_W-1:0] accel_range_code,
   input  wire logic [GYRO_CODE_W-1:0]  gyro_range_code,
   output logic                         q_valid,
   input  wire logic                    q_ready,
   output item_type                     q_item
);

   logic       f0_v_ff, f0_v_in;
   logic       f1_v_ff, f1_v_in;
   logic       f0_move, f1_move;
   logic       err_ff, gyro_ff;
   raw_type    raw_ff [AXES];
   factor_type factor_ff;
   item_type   item_ff, item_in;
   prod_type   prod [AXES];
   prod_type   rnd [AXES];
   scaled_type scaled [AXES];

   assign f1_move    = !f1_v_ff || q_ready;
   assign f0_move    = !f0_v_ff || f1_move;
   assign req_tready = f0_move;

   assign f0_v_in = f0_move ? req_tvalid : f0_v_ff;
   assign f1_v_in = f1_move ? f0_v_ff : f1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_v_ff <= 1'b0;
         f1_v_ff <= 1'b0;
      end else begin
         f0_v_ff <= f0_v_in;
         f1_v_ff <= f1_v_in;
      end
   end

   // stage 0: capture and pick the scale factor for the sensor
   always_ff @(posedge clock) begin
      if (f0_move && req_tvalid) begin
         gyro_ff   <= req_tuser[0];
         err_ff    <= req_tuser[1];
         factor_ff <= req_tuser[0] ? gyro_scale(gyro_range_code)
                                   : accel_scale(accel_range_code);
         for (int i = 0; i < AXES; i++) begin
            raw_ff[i] <= req_tdata[i*RAW_W +: RAW_W];
         end
      end
   end

   // stage 1: raw * factor, round half up at bit 16
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         prod[i]   = raw_ff[i] * $signed({1'b0, factor_ff});
         rnd[i]    = prod[i] + $signed(SCALE_ROUND);
         scaled[i] = rnd[i][SCALE_SHIFT +: SCALED_W];
      end
      item_in.err  = err_ff;
      item_in.gyro = gyro_ff;
      item_in.sx   = scaled[0];
      item_in.sy   = scaled[1];
      item_in.sz   = scaled[2];
   end

   always_ff @(posedge clock) begin
      if (f1_move && f0_v_ff) begin
         item_ff <= item_in;
      end
   end

   assign q_valid = f1_v_ff;
   assign q_item  = item_ff;

endmodule
`default_nettype wire

### rtl/imu_ssc_queue.sv
`default_nettype none
module imu_ssc_queue import imu_ssc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  item_type  in_item,
   output logic      out_valid,
   input  wire logic out_ready,
   output item_type  out_item
);

   item_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

### rtl/imu_ssc_back.sv
`default_nettype none
module imu_ssc_back import imu_ssc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   output logic                        q_ready,
   input  item_type                    q_item,
   input  wire logic [BIAS_PACK_W-1:0] accel_bias_packed,
   input  wire logic [BIAS_PACK_W-1:0] gyro_bias_packed,
   input  wire logic [ROW_W-1:0]       align_row_x,
   input  wire logic [ROW_W-1:0]       align_row_y,
   input  wire logic [ROW_W-1:0]       align_row_z,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tuser,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic                   b0_v_ff, b0_v_in, b1_v_ff, b1_v_in, out_v_ff, out_v_in;
   logic                   b0_move, b1_move, out_move;
   logic                   b0_err_ff, b0_gyro_ff, b1_err_ff, b1_gyro_ff;
   logic [BIAS_PACK_W-1:0] bias_sel;
   logic [ROW_W-1:0]       row [AXES];
   scaled_type             sc_in [AXES];
   nb_type                 nb_in [AXES];
   scaled_type             b0_sc_ff [AXES];
   scaled_type             b1_sc_ff [AXES];
   nb_type                 b0_nb_ff [AXES];
   nb_type                 b1_nb_ff [AXES];
   prod_type               b1_prod_ff [AXES][AXES];
   dot_type                dot [AXES];
   logic signed [DOT_W-ALIGN_SHIFT-1:0] dot_q [AXES];
   out_type                cal_in [AXES];
   logic                   status_ff;
   logic [RSP_TDATA_W-1:0] tdata_ff, tdata_in;

   assign out_move = !out_v_ff || rsp_tready;
   assign b1_move  = !b1_v_ff || out_move;
   assign b0_move  = !b0_v_ff || b1_move;
   assign q_ready  = b0_move;

   assign b0_v_in  = b0_move ? q_valid : b0_v_ff;
   assign b1_v_in  = b1_move ? b0_v_ff : b1_v_ff;
   assign out_v_in = out_move ? b1_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_v_ff  <= 1'b0;
         b1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         b0_v_ff  <= b0_v_in;
         b1_v_ff  <= b1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // stage 0: bias removal, exact at Q16
   assign bias_sel = q_item.gyro ? gyro_bias_packed : accel_bias_packed;
   assign sc_in[0] = q_item.sx;
   assign sc_in[1] = q_item.sy;
   assign sc_in[2] = q_item.sz;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         nb_in[i] = NB_W'(sc_in[i]) - NB_W'($signed(bias_sel[i*BIAS_W +: BIAS_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (b0_move && q_valid) begin
         b0_err_ff  <= q_item.err;
         b0_gyro_ff <= q_item.gyro;
         for (int i = 0; i < AXES; i++) begin
            b0_sc_ff[i] <= sc_in[i];
            b0_nb_ff[i] <= nb_in[i];
         end
      end
   end

   // stage 1: nine Q2.14 x Q16 products
   assign row[0] = align_row_x;
   assign row[1] = align_row_y;
   assign row[2] = align_row_z;

   always_ff @(posedge clock) begin
      if (b1_move && b0_v_ff) begin
         b1_err_ff  <= b0_err_ff;
         b1_gyro_ff <= b0_gyro_ff;
         for (int r = 0; r < AXES; r++) begin
            b1_sc_ff[r] <= b0_sc_ff[r];
            b1_nb_ff[r] <= b0_nb_ff[r];
            for (int c = 0; c < AXES; c++) begin
               b1_prod_ff[r][c] <= $signed(row[r][c*COEF_W +: COEF_W]) * b0_nb_ff[c];
            end
         end
      end
   end

   // stage 2: accel row sums, round half up to Q16; gyro passes bias-removed
   // values; error words give zero data; well inside 32 bits, no saturation
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         dot[r]   = DOT_W'(b1_prod_ff[r][0]) + DOT_W'(b1_prod_ff[r][1])
                  + DOT_W'(b1_prod_ff[r][2]) + $signed(ALIGN_ROUND);
         dot_q[r] = dot[r][DOT_W-1:ALIGN_SHIFT];
         cal_in[r] = b1_gyro_ff ? OUT_W'(b1_nb_ff[r]) : OUT_W'(dot_q[r]);
      end
      tdata_in = '0;
      if (!b1_err_ff) begin
         for (int i = 0; i < AXES; i++) begin
            tdata_in[i*OUT_W +: OUT_W]        = OUT_W'(b1_sc_ff[i]);
            tdata_in[(AXES+i)*OUT_W +: OUT_W] = cal_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && b1_v_ff) begin
         status_ff <= b1_err_ff;
         tdata_ff  <= tdata_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = tdata_ff;

endmodule
`default_nettype wire

### rtl/imu_sample_scale_calibrate.sv
// Channel  Dir  Width  Contents
// req      in   48+2   tdata raw_x, raw_y, raw_z; tuser func, bus_error
// rsp      out  192+1  tdata scaled_x/y/z, calibrated_x/y/z; tuser status
// csr      in   3+64   csr_index register number, csr_data value
//
// One word per cycle sustained while rsp is not stalled.
// Front: capture and scale multiply (2 stages); back: bias, 3x3 products,
// row sum (3 stages); a 4-word queue sits between them.
// Synchronous reset clears all valid state and loads register defaults.
// A stall on rsp only backs up the back end until the queue fills.
`default_nettype none
module imu_sample_scale_calibrate import imu_ssc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,  // func, bus_error
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // raw_x, raw_y, raw_z
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tuser,  // status
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // scaled_x/y/z, calibrated_x/y/z
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic [ACCEL_CODE_W-1:0] accel_range_ff, accel_range_in;
   logic [GYRO_CODE_W-1:0]  gyro_range_ff, gyro_range_in;
   logic [BIAS_PACK_W-1:0]  accel_bias_ff, accel_bias_in;
   logic [BIAS_PACK_W-1:0]  gyro_bias_ff, gyro_bias_in;
   logic [ROW_W-1:0]        row_x_ff, row_x_in;
   logic [ROW_W-1:0]        row_y_ff, row_y_in;
   logic [ROW_W-1:0]        row_z_ff, row_z_in;

   logic     q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   item_type q_in_item, q_out_item;

   assign csr_ready = 1'b1;

   always_comb begin
      accel_range_in = accel_range_ff;
      gyro_range_in  = gyro_range_ff;
      accel_bias_in  = accel_bias_ff;
      gyro_bias_in   = gyro_bias_ff;
      row_x_in       = row_x_ff;
      row_y_in       = row_y_ff;
      row_z_in       = row_z_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_RANGE: accel_range_in = csr_data[ACCEL_CODE_W-1:0];
            CSR_GYRO_RANGE:  gyro_range_in  = csr_data[GYRO_CODE_W-1:0];
            CSR_ACCEL_BIAS:  accel_bias_in  = csr_data[BIAS_PACK_W-1:0];
            CSR_GYRO_BIAS:   gyro_bias_in   = csr_data[BIAS_PACK_W-1:0];
            CSR_ALIGN_X:     row_x_in       = csr_data[ROW_W-1:0];
            CSR_ALIGN_Y:     row_y_in       = csr_data[ROW_W-1:0];
            CSR_ALIGN_Z:     row_z_in       = csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_range_ff <= ACCEL_RANGE_RST;
         gyro_range_ff  <= GYRO_RANGE_RST;
         accel_bias_ff  <= '0;
         gyro_bias_ff   <= '0;
         row_x_ff       <= ALIGN_ROW_X_RST;
         row_y_ff       <= ALIGN_ROW_Y_RST;
         row_z_ff       <= ALIGN_ROW_Z_RST;
      end else begin
         accel_range_ff <= accel_range_in;
         gyro_range_ff  <= gyro_range_in;
         accel_bias_ff  <= accel_bias_in;
         gyro_bias_ff   <= gyro_bias_in;
         row_x_ff       <= row_x_in;
         row_y_ff       <= row_y_in;
         row_z_ff       <= row_z_in;
      end
   end

   imu_ssc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .accel_range_code (accel_range_ff),
      .gyro_range_code  (gyro_range_ff),
      .q_valid          (q_in_valid),
      .q_ready          (q_in_ready),
      .q_item           (q_in_item)
   );

   imu_ssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_item   (q_in_item),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_item  (q_out_item)
   );

   imu_ssc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_out_valid),
      .q_ready           (q_out_ready),
      .q_item            (q_out_item),
      .accel_bias_packed (accel_bias_ff),
      .gyro_bias_packed  (gyro_bias_ff),
      .align_row_x       (row_x_ff),
      .align_row_y       (row_y_ff),
      .align_row_z       (row_z_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tuser         (rsp_tuser),
      .rsp_tdata         (rsp_tdata)
   );

endmodule
`default_nettype wire

### rtl/imu_ssc_checker.sv
`default_nettype none
`include "imu_sample_scale_calibrate_defines.svh"
module imu_ssc_checker import imu_ssc_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic                   rsp_tuser,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a word held back stays offered
   `IMU_SSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // and keeps its payload
   `IMU_SSC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))

   // nothing comes out of a cleared pipeline
   `IMU_SSC_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)

   // read errors carry all-zero data
   `IMU_SSC_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)

endmodule

bind imu_sample_scale_calibrate imu_ssc_checker u_checker (.*);
`default_nettype wire
